// ===== hw/rtl/asb_pkg.sv =====
// Shared types, constants and GF(2^8) helper functions for the AES S-box core.
`default_nettype none

package asb_pkg;

    localparam logic OP_FWD = 1'b0;
    localparam logic OP_INV = 1'b1;

    localparam logic [7:0] RED_POLY_LOW     = 8'h1b;
    localparam logic [7:0] AFFINE_CONST     = 8'h63;
    localparam logic [7:0] INV_AFFINE_CONST = 8'h05;

    // One word in flight: operation bit plus the byte being worked on.
    typedef struct packed {
        logic       op;
        logic [7:0] val;
    } t_lane;

    function automatic logic [7:0] gf_xtime(input logic [7:0] a);
        gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? RED_POLY_LOW : 8'h00);
    endfunction

    // Shift-and-add multiply, MSB first, reducing mod 0x11b on the way.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--) begin
            acc = gf_xtime(acc) ^ (a[i] ? b : 8'h00);
        end
        gf_mul = acc;
    endfunction

    // Squaring is linear over GF(2); synthesis folds this into an XOR network.
    function automatic logic [7:0] gf_sq(input logic [7:0] a);
        gf_sq = gf_mul(a, a);
    endfunction

    function automatic logic [7:0] affine_fwd(input logic [7:0] w);
        affine_fwd = w ^ {w[6:0], w[7]} ^ {w[5:0], w[7:6]} ^ {w[4:0], w[7:5]}
                   ^ {w[3:0], w[7:4]} ^ AFFINE_CONST;
    endfunction

    function automatic logic [7:0] affine_inv(input logic [7:0] y);
        affine_inv = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]}
                   ^ INV_AFFINE_CONST;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/asb_if.sv =====
// Valid/ready channel interfaces for the S-box input and result words.
`default_nettype none

interface asb_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_in;

    modport source (output valid, output operation, output data_in, input ready);
    modport sink   (input valid, input operation, input data_in, output ready);
endinterface

interface asb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/asb_pre.sv =====
// Input stage: registers the word and applies the inverse affine map in inverse mode.
`default_nettype none

module asb_pre (
    input  wire            i_clk,
    input  wire            i_rst_n,
    asb_in_if.sink         i_in,
    output logic           o_valid,
    output asb_pkg::t_lane o_lane,
    input  wire            i_ready
);

    logic           r_valid;
    asb_pkg::t_lane r_lane;
    asb_pkg::t_lane n_lane;
    logic           adv;

    assign adv        = !r_valid || i_ready;
    assign i_in.ready = adv;

    always_comb begin
        n_lane.op  = i_in.operation;
        n_lane.val = (i_in.operation == asb_pkg::OP_INV) ? asb_pkg::affine_inv(i_in.data_in)
                                                         : i_in.data_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

`default_nettype wire

// ===== hw/rtl/asb_inv.sv =====
// Three-stage GF(2^8) inversion pipeline, x^254 via an addition chain of three multiply levels.
`default_nettype none

module asb_inv (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  wire asb_pkg::t_lane i_lane,
    output logic           o_ready,
    output logic           o_valid,
    output asb_pkg::t_lane o_lane,
    input  wire            i_ready
);

    typedef struct packed {
        logic       op;
        logic [7:0] x2;
        logic [7:0] x3;
    } t_s2;

    typedef struct packed {
        logic       op;
        logic [7:0] x14;
        logic [7:0] x15;
    } t_s3;

    logic           r_v2, r_v3, r_v4;
    t_s2            r_s2, n_s2;
    t_s3            r_s3, n_s3;
    asb_pkg::t_lane r_s4, n_s4;
    logic           rdy2, rdy3, rdy4;
    logic [7:0]     x12;
    logic [7:0]     x240;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign o_ready = rdy2;

    // x^2, x^3
    always_comb begin
        n_s2.op = i_lane.op;
        n_s2.x2 = asb_pkg::gf_sq(i_lane.val);
        n_s2.x3 = asb_pkg::gf_mul(n_s2.x2, i_lane.val);
    end

    // x^12 = (x^3)^4; x^14 = x^12 * x^2; x^15 = x^12 * x^3
    always_comb begin
        x12      = asb_pkg::gf_sq(asb_pkg::gf_sq(r_s2.x3));
        n_s3.op  = r_s2.op;
        n_s3.x14 = asb_pkg::gf_mul(x12, r_s2.x2);
        n_s3.x15 = asb_pkg::gf_mul(x12, r_s2.x3);
    end

    // x^240 = (x^15)^16; x^254 = x^240 * x^14, zero stays zero
    always_comb begin
        x240     = asb_pkg::gf_sq(asb_pkg::gf_sq(asb_pkg::gf_sq(asb_pkg::gf_sq(r_s3.x15))));
        n_s4.op  = r_s3.op;
        n_s4.val = asb_pkg::gf_mul(x240, r_s3.x14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_v2 <= i_valid;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && i_valid) begin
            r_s2 <= n_s2;
        end
        if (rdy3 && r_v2) begin
            r_s3 <= n_s3;
        end
        if (rdy4 && r_v3) begin
            r_s4 <= n_s4;
        end
    end

    assign o_valid = r_v4;
    assign o_lane  = r_s4;

    a_adv_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && rdy3) |=> r_v3)
        else $error("stage 2 word not moved into stage 3");

    a_zero_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_s2.x2 == 8'h00) |-> (r_s2.x3 == 8'h00))
        else $error("x^3 nonzero for zero element");

    a_hold_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy4) |=> (r_v3 && $stable(r_s3)))
        else $error("stalled stage 3 word lost or changed");

endmodule

`default_nettype wire

// ===== hw/rtl/aes_sbox_forward_inverse_core.sv =====
// Top level of the AES S-box core: input stage, inversion pipeline, affine output stage.
// Computes the AES S-box (operation 0) or inverse S-box (operation 1) from its
// definition, with no table. Five register stages: input plus inverse affine map,
// three GF(2^8) inversion stages (x^254 by an addition chain, one level of 8x8
// carry-less multiplies per stage), and an output register holding the forward affine
// map. One word per cycle is accepted while the output takes results, and a stall on
// the output fills the bubbles before the input ready drops. No state survives between
// words; reset only clears the valid bits.
`default_nettype none

module aes_sbox_forward_inverse_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    asb_in_if.sink     i_in,
    asb_out_if.source  o_out
);

    logic           pre_valid;
    asb_pkg::t_lane pre_lane;
    logic           pre_ready;
    logic           inv_valid;
    asb_pkg::t_lane inv_lane;
    logic           inv_ready;

    logic           r_out_valid;
    logic [7:0]     r_out_data;
    logic [7:0]     n_out_data;

    asb_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (pre_valid),
        .o_lane  (pre_lane),
        .i_ready (pre_ready)
    );

    asb_inv u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pre_valid),
        .i_lane  (pre_lane),
        .o_ready (pre_ready),
        .o_valid (inv_valid),
        .o_lane  (inv_lane),
        .i_ready (inv_ready)
    );

    assign inv_ready  = !r_out_valid || o_out.ready;
    assign n_out_data = (inv_lane.op == asb_pkg::OP_FWD) ? asb_pkg::affine_fwd(inv_lane.val)
                                                         : inv_lane.val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (inv_ready) begin
            r_out_valid <= inv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (inv_ready && inv_valid) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.data_out = r_out_data;

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_out.ready && !inv_valid) |=> !r_out_valid)
        else $error("result word repeated after being taken");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (inv_valid && inv_ready) |=> r_out_valid)
        else $error("inversion word dropped at output stage");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid) |-> inv_ready)
        else $error("empty output stage backpressures pipeline");

endmodule

`default_nettype wire

// ===== sim/aes_sbox_checker.sv =====
// Scoreboard for the AES S-box core: predicts each substituted byte and checks the results.
`default_nettype none

module aes_sbox_checker (
    input  wire  i_clk,
    input  wire  i_rst_n,
    asb_in_if    in_mon,
    asb_out_if   out_mon,
    output int   o_mismatches,
    output int   o_due
);

    logic [7:0] sbox_due_q[$];

    // GF(2^8) product, LSB first: shift a up and reduce by x^8+x^4+x^3+x+1.
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] sh;
        prod = 8'h00;
        sh   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) prod = prod ^ sh;
            sh = {sh[6:0], 1'b0} ^ (sh[7] ? 8'h1b : 8'h00);
        end
        return prod;
    endfunction

    // x^254 = x^2 * x^4 * ... * x^128; zero falls out as zero.
    function automatic logic [7:0] gf_recip(input logic [7:0] x);
        logic [7:0] pw;
        logic [7:0] acc;
        pw  = x;
        acc = 8'h01;
        for (int k = 0; k < 7; k++) begin
            pw  = gf_times(pw, pw);
            acc = gf_times(acc, pw);
        end
        return acc;
    endfunction

    // Forward affine: bit i = w[i]^w[i+4]^w[i+5]^w[i+6]^w[i+7], indices mod 8.
    function automatic logic [7:0] affine_map(input logic [7:0] w);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = w[i] ^ w[(i + 4) % 8] ^ w[(i + 5) % 8] ^ w[(i + 6) % 8]
                 ^ w[(i + 7) % 8];
        end
        return r ^ asb_pkg::AFFINE_CONST;
    endfunction

    // Inverse affine: bit i = y[i+2]^y[i+5]^y[i+7], then the folded constant.
    function automatic logic [7:0] affine_unmap(input logic [7:0] y);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = y[(i + 2) % 8] ^ y[(i + 5) % 8] ^ y[(i + 7) % 8];
        end
        return r ^ asb_pkg::INV_AFFINE_CONST;
    endfunction

    function automatic logic [7:0] sbox_predict(input logic op, input logic [7:0] d);
        if (op == asb_pkg::OP_FWD) return affine_map(gf_recip(d));
        return gf_recip(affine_unmap(d));
    endfunction

    initial begin
        o_mismatches = 0;
        o_due        = 0;
    end

    always @(posedge i_clk) begin
        logic [7:0] want;
        if (i_rst_n) begin
            if (in_mon.valid && in_mon.ready) begin
                sbox_due_q.push_back(sbox_predict(in_mon.operation, in_mon.data_in));
            end
            if (out_mon.valid && out_mon.ready) begin
                if (sbox_due_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %02h",
                             $time, out_mon.data_out);
                    o_mismatches = o_mismatches + 1;
                end else begin
                    want = sbox_due_q.pop_front();
                    if (out_mon.data_out !== want) begin
                        $display("%0t: data_out mismatch, expected %02h, actual %02h",
                                 $time, want, out_mon.data_out);
                        o_mismatches = o_mismatches + 1;
                    end
                end
            end
            o_due = sbox_due_q.size();
        end
    end

endmodule

`default_nettype wire

// ===== sim/tb_aes_sbox_forward_inverse_core.sv =====
// Testbench top for the AES S-box core: clock, reset, stimulus, back-pressure and verdict.
`default_nettype none

module tb_aes_sbox_forward_inverse_core;

    localparam int RAND_WORDS = 1700;
    localparam int HOLD_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   due;
    bit   calm = 1'b0;
    bit   hold_req = 1'b0;

    asb_in_if  in_ch();
    asb_out_if out_ch();

    aes_sbox_forward_inverse_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    aes_sbox_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .o_mismatches (mismatches),
        .o_due        (due)
    );

    always #5 clk = ~clk;

    task automatic drive_word(input logic op, input logic [7:0] d);
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_in   <= d;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 96) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, one long hold on request, none while calm.
    initial begin
        int stall_left;
        int hold_left;
        int r;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end else if (calm) begin
                out_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    out_ch.ready <= 1'b1;
                end else if (r < 96) begin
                    out_ch.ready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end else begin
                    out_ch.ready <= 1'b0;
                    stall_left = $urandom_range(10, 30);
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [7:0] d;
        logic       op;
        int         r;
        in_ch.valid     = 1'b0;
        in_ch.operation = asb_pkg::OP_FWD;
        in_ch.data_in   = 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero element both ways, ends of the byte range, a few known pairs.
        drive_word(asb_pkg::OP_FWD, 8'h00);
        drive_word(asb_pkg::OP_INV, 8'h63);
        drive_word(asb_pkg::OP_FWD, 8'hff);
        drive_word(asb_pkg::OP_INV, 8'hff);
        drive_word(asb_pkg::OP_FWD, 8'h01);
        drive_word(asb_pkg::OP_INV, 8'h01);
        drive_word(asb_pkg::OP_INV, 8'h00);
        drive_word(asb_pkg::OP_FWD, 8'h80);
        drive_word(asb_pkg::OP_INV, 8'h80);
        drive_word(asb_pkg::OP_FWD, 8'h53);
        drive_word(asb_pkg::OP_INV, 8'hed);
        drive_word(asb_pkg::OP_FWD, 8'h7f);
        drive_word(asb_pkg::OP_FWD, 8'hfe);
        drive_word(asb_pkg::OP_INV, 8'h16);
        drive_word(asb_pkg::OP_INV, 8'h7c);
        drive_word(asb_pkg::OP_FWD, 8'h55);
        drive_word(asb_pkg::OP_FWD, 8'haa);
        drive_word(asb_pkg::OP_INV, 8'h55);
        drive_word(asb_pkg::OP_INV, 8'haa);
        drive_word(asb_pkg::OP_FWD, 8'h02);
        idle_cycles(3);

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == 300) hold_req = 1'b1;
            calm = (n >= 600 && n < 800);
            if (n == 1000) begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
                wait (due == 0);
                @(posedge clk);
            end
            // no sender gaps while the receiver holds off, so the pipe backs up
            if (!calm && !(n >= 300 && n < 400)) idle_cycles(pick_gap());
            op = 1'($urandom_range(0, 1));
            r  = $urandom_range(0, 99);
            if (r < 3) d = 8'h00;
            else if (r < 6) d = 8'hff;
            else if (r < 9) d = 8'h63;
            else d = 8'($urandom_range(0, 255));
            drive_word(op, d);
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;
        // let the scoreboard count the last word before waiting on it
        @(posedge clk);

        wait (due == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
